// File: sv/rhs_pkg.sv
// rhs_pkg: shared constants and types of the prefix rolling hash store
// depends on nothing; used by every rhs module and the top level
package rhs_pkg;

    localparam int MAX_LEN = 1024;
    localparam int DEPTH   = MAX_LEN + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int HASH_W  = 31;
    localparam int STEP_W  = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(131);
    localparam logic [HASH_W-1:0] MOD_RESET  = HASH_W'(1000000007);

    // actions
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_BAD_RANGE = 2'd3;

    // config register indexes
    localparam logic CFG_BASE    = 1'b0;
    localparam logic CFG_MODULUS = 1'b1;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] m;
    } mm_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [HASH_W-1:0] r;
    } mm_rsp_t;

endpackage

// File: sv/prefix_rolling_hash_store.sv
// prefix_rolling_hash_store: top level, control sequencer and the two hash tables
// depends on rhs_pkg, rhs_ram, rhs_modmul
//
// keeps a string as prefix hashes H[k] and base powers P[k] modulo a configurable modulus
// input channel s_*: one item per action (push, pop, clear, query), kind in s_tuser
// result channel m_*: exactly one item per input item, in order
// config port: cfg_we writes cfg_wdata into register cfg_addr (0 base, 1 modulus);
//   the user must write only while the block is idle; the block does not enforce it
// all modular products run through one bit-serial multiplier;
//   its four passes per push set the rate
// pop, clear, full push, empty pop and bad query range go straight to the result;
//   a query takes three multiplier passes, a push four
// s_tready rises as a result is loaded into the output register
// one item is worked on at a time; s_tready is high only when the sequencer is idle
// a finished result sits in the output register; the next item is accepted while it
//   waits, and that item's result is held until the receiver takes the previous one
// reset (synchronous, aresetn low) empties the string, loads base 131 and modulus
//   1000000007; table entry 0 reads as its reset value (H 0, P 1) by logic, never stored
module prefix_rolling_hash_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config write port
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [rhs_pkg::HASH_W-1:0]  cfg_wdata,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // char_value[7:0], left_index[17:8],
                                                   // right_index[27:18], zero pad
    input  logic [1:0]                  s_tuser,   // action[1:0]
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // hash_value[30:0], length[41:31], zero pad
    output logic [1:0]                  m_tuser    // status[1:0]
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PU_RD  = 4'd1;
    localparam logic [3:0] S_PU_B   = 4'd2;
    localparam logic [3:0] S_PU_CH  = 4'd3;
    localparam logic [3:0] S_PU_H   = 4'd4;
    localparam logic [3:0] S_PU_P   = 4'd5;
    localparam logic [3:0] S_Q_RD   = 4'd6;
    localparam logic [3:0] S_Q_HR   = 4'd7;
    localparam logic [3:0] S_Q_PW   = 4'd8;
    localparam logic [3:0] S_Q_T    = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    localparam int HW = rhs_pkg::HASH_W;
    localparam int AW = rhs_pkg::ADDR_W;

    // config registers
    logic [HW-1:0] base_cfg_reg;
    logic [HW-1:0] mod_cfg_reg;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] count_reg, count_next;

    // item fields
    logic [1:0]    act_in;
    logic [7:0]    char_in;
    logic [9:0]    left_in, right_in;
    logic [7:0]    char_reg;
    logic [9:0]    left_reg;

    // working registers
    logic [HW-1:0] m_reg;      // effective modulus of this item
    logic [HW-1:0] hx_reg, hx_next;
    logic [HW-1:0] px_reg, px_next;
    logic [HW-1:0] base_reg, base_next;
    logic [HW-1:0] acc_reg, acc_next;
    logic [HW-1:0] res_hash_reg, res_hash_next;
    logic [1:0]    res_st_reg, res_st_next;

    // output register
    logic          m_tvalid_reg;
    logic [HW-1:0] out_hash_reg;
    logic [AW-1:0] out_len_reg;
    logic [1:0]    out_st_reg;

    // tables
    logic          tab_we;
    logic [AW-1:0] tab_waddr;
    logic          h_re, p_re;
    logic [AW-1:0] h_raddr, p_raddr;
    logic [HW-1:0] h_rdata, p_rdata;

    rhs_pkg::mm_req_t mm_req;
    rhs_pkg::mm_rsp_t mm_rsp;

    logic          accept;
    logic          out_free;
    logic          bad_range;
    logic [AW-1:0] right_ext, left_ext;
    logic [HW:0]   mod_sum;

    assign act_in   = s_tuser;
    assign char_in  = s_tdata[7:0];
    assign left_in  = s_tdata[17:8];
    assign right_in = s_tdata[27:18];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign right_ext = AW'(right_in);
    assign left_ext  = AW'(left_in);
    assign bad_range = (left_in > right_in) || (right_ext >= count_reg);

    rhs_ram u_prefix (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (hx_reg),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    rhs_ram u_power (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (mm_rsp.r),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rhs_modmul u_mm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_cfg_reg <= rhs_pkg::BASE_RESET;
            mod_cfg_reg  <= rhs_pkg::MOD_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                rhs_pkg::CFG_BASE:    base_cfg_reg <= cfg_wdata;
                rhs_pkg::CFG_MODULUS: mod_cfg_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        hx_next       = hx_reg;
        px_next       = px_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        res_hash_next = res_hash_reg;
        res_st_next   = res_st_reg;
        tab_we        = 1'b0;
        tab_waddr     = count_reg + 1'b1;
        h_re          = 1'b0;
        p_re          = 1'b0;
        h_raddr       = count_reg;
        p_raddr       = count_reg;
        mm_req.start  = 1'b0;
        mm_req.a      = '0;
        mm_req.b      = HW'(1);
        mm_req.m      = m_reg;
        mod_sum       = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_hash_next = '0;
                    res_st_next   = rhs_pkg::ST_OK;
                    state_next    = S_EMIT;
                    case (act_in)
                        rhs_pkg::ACT_PUSH: begin
                            if (count_reg >= AW'(rhs_pkg::MAX_LEN)) begin
                                res_st_next = rhs_pkg::ST_FULL;
                            end else begin
                                h_re       = 1'b1;
                                p_re       = 1'b1;
                                state_next = S_PU_RD;
                            end
                        end
                        rhs_pkg::ACT_POP: begin
                            if (count_reg == '0) begin
                                res_st_next = rhs_pkg::ST_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        rhs_pkg::ACT_CLEAR: begin
                            count_next = '0;
                        end
                        rhs_pkg::ACT_QUERY: begin
                            if (bad_range) begin
                                res_st_next = rhs_pkg::ST_BAD_RANGE;
                            end else begin
                                h_re       = 1'b1;
                                p_re       = 1'b1;
                                h_raddr    = right_ext + 1'b1;
                                p_raddr    = right_ext - left_ext + 1'b1;
                                state_next = S_Q_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // push: H[n], P[n] arrive; entry 0 is the reset value
            S_PU_RD: begin
                hx_next      = (count_reg == '0) ? '0 : h_rdata;
                px_next      = (count_reg == '0) ? HW'(1) : p_rdata;
                mm_req.start = 1'b1;
                mm_req.a     = base_cfg_reg;
                state_next   = S_PU_B;
            end
            S_PU_B: begin
                if (mm_rsp.done) begin
                    base_next    = mm_rsp.r;
                    mm_req.start = 1'b1;
                    mm_req.a     = HW'(char_reg);
                    state_next   = S_PU_CH;
                end
            end
            S_PU_CH: begin
                if (mm_rsp.done) begin
                    acc_next     = mm_rsp.r;
                    mm_req.start = 1'b1;
                    mm_req.a     = hx_reg;
                    mm_req.b     = base_reg;
                    state_next   = S_PU_H;
                end
            end
            S_PU_H: begin
                if (mm_rsp.done) begin
                    mod_sum      = {1'b0, mm_rsp.r} + {1'b0, acc_reg};
                    hx_next      = (mod_sum >= {1'b0, m_reg}) ? HW'(mod_sum - {1'b0, m_reg})
                                                              : mod_sum[HW-1:0];
                    mm_req.start = 1'b1;
                    mm_req.a     = px_reg;
                    mm_req.b     = base_reg;
                    state_next   = S_PU_P;
                end
            end
            S_PU_P: begin
                if (mm_rsp.done) begin
                    tab_we        = 1'b1;
                    count_next    = count_reg + 1'b1;
                    res_hash_next = hx_reg;
                    state_next    = S_EMIT;
                end
            end
            // query: H[r+1] and P[r-l+1] arrive, fetch H[l] next
            S_Q_RD: begin
                px_next      = p_rdata;
                h_re         = 1'b1;
                h_raddr      = AW'(left_reg);
                mm_req.start = 1'b1;
                mm_req.a     = h_rdata;
                state_next   = S_Q_HR;
            end
            S_Q_HR: begin
                if (mm_rsp.done) begin
                    acc_next     = mm_rsp.r;
                    mm_req.start = 1'b1;
                    mm_req.a     = px_reg;
                    state_next   = S_Q_PW;
                end
            end
            S_Q_PW: begin
                if (mm_rsp.done) begin
                    mm_req.start = 1'b1;
                    mm_req.a     = (left_reg == '0) ? '0 : h_rdata;
                    mm_req.b     = mm_rsp.r;
                    state_next   = S_Q_T;
                end
            end
            S_Q_T: begin
                if (mm_rsp.done) begin
                    res_hash_next = (acc_reg >= mm_rsp.r) ? acc_reg - mm_rsp.r
                                                          : acc_reg + (m_reg - mm_rsp.r);
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        hx_reg       <= hx_next;
        px_reg       <= px_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        res_hash_reg <= res_hash_next;
        res_st_reg   <= res_st_next;
        if (accept) begin
            char_reg <= char_in;
            left_reg <= left_in;
            // modulus below two acts as one
            m_reg    <= (mod_cfg_reg < HW'(2)) ? HW'(1) : mod_cfg_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free) begin
            out_hash_reg <= res_hash_reg;
            out_len_reg  <= count_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_len_reg, out_hash_reg};
    assign m_tuser  = out_st_reg;

    // string never grows past the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= AW'(rhs_pkg::MAX_LEN))
        else $error("character count beyond table depth");

    // multiplier is free whenever a new item can be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mm_rsp.busy)
        else $error("multiplier busy while idle");

    // push on a full string goes straight to the result with the full status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && act_in == rhs_pkg::ACT_PUSH && count_reg == AW'(rhs_pkg::MAX_LEN))
        |=> (state_reg == S_EMIT && res_st_reg == rhs_pkg::ST_FULL))
        else $error("full push not flagged");

    // table written only on a completing push
    assert property (@(posedge aclk) disable iff (!aresetn)
        tab_we |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("table write without count advance");

endmodule

// File: sv/rhs_ram.sv
// rhs_ram: one-write one-read synchronous table of hash words
// depends on rhs_pkg for depth and widths
module rhs_ram (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [rhs_pkg::ADDR_W-1:0]  waddr,
    input  logic [rhs_pkg::HASH_W-1:0]  wdata,
    input  logic                        re,
    input  logic [rhs_pkg::ADDR_W-1:0]  raddr,
    output logic [rhs_pkg::HASH_W-1:0]  rdata
);

    logic [rhs_pkg::HASH_W-1:0] mem [rhs_pkg::DEPTH];
    logic [rhs_pkg::HASH_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rhs_modmul.sv
// rhs_modmul: bit-serial modular multiply, r = a * b mod m, one bit of a per cycle
// depends on rhs_pkg; needs b <= m and m >= 1
module rhs_modmul (
    input  logic              aclk,
    input  logic              aresetn,
    input  rhs_pkg::mm_req_t  req,
    output rhs_pkg::mm_rsp_t  rsp
);

    logic [rhs_pkg::HASH_W-1:0] a_reg, a_next;
    logic [rhs_pkg::HASH_W-1:0] b_reg;
    logic [rhs_pkg::HASH_W-1:0] m_reg;
    logic [rhs_pkg::HASH_W-1:0] r_reg, r_next;
    logic [rhs_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [rhs_pkg::HASH_W:0] dbl, dbl_red, sum, m_ext;

    // double, reduce, conditionally add b, reduce
    always_comb begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (a_reg[rhs_pkg::HASH_W-1] ? {1'b0, b_reg} : '0);
        r_next  = (sum >= m_ext) ? rhs_pkg::HASH_W'(sum - m_ext)
                                 : sum[rhs_pkg::HASH_W-1:0];
        a_next  = {a_reg[rhs_pkg::HASH_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            m_reg   <= req.m;
            r_reg   <= '0;
            cnt_reg <= rhs_pkg::STEP_W'(rhs_pkg::HASH_W - 1);
        end else if (busy_reg) begin
            a_reg   <= a_next;
            r_reg   <= r_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.r    = r_reg;

endmodule
